>>> rtl/mfn_pkg.sv
// shared widths and the cross product index tables for the face morph and normal block
`timescale 1ns / 1ps
package mfn_pkg;

  localparam int CW        = 32;            // coordinate width
  localparam int NW        = 16;            // normal width, signed Q2.(NW-2)
  localparam int SW        = 12;            // speed register width
  localparam int MORPH_DIV = 1000;

  localparam int PW   = CW + SW;            // speed times delta
  localparam int VW   = CW + 1;             // vertex difference
  localparam int MW   = 30;                 // reduced magnitude width
  localparam int VMW  = (VW > MW) ? VW : MW;
  localparam int NACC = 2 * MW + 2;         // signed cross product component
  localparam int NMW  = 2 * MW + 1;         // its magnitude
  localparam int SQW  = 2 * MW + 2;         // sum of squares
  localparam int RW   = SQW + 1;            // square root work width
  localparam int NUMW = NW + MW;            // normal division dividend
  localparam int DVW  = (PW > NUMW) ? PW : NUMW;
  localparam int DSW  = MW + 2;             // divisor width
  localparam int SUMW = DVW + 2;            // morph sum before saturation

  // cross product term j uses v1[xa_idx(j)] * v2[xb_idx(j)], odd terms subtract
  function automatic logic [1:0] xa_idx(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] xb_idx(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/morph_face_and_normal_top.sv
// triangle vertex morph with shared unit face normal, serial datapath
//
//  channel | dir | handshake             | carries
//  in      | in  | in_valid_i/in_ready_o  | cur_*, delta_* of one vertex
//  out     | out | out_valid_o/out_ready_i| vertex_slot, new_*, normal_*, last_of_face
//  cfg     | in  | cfg_valid_i/cfg_ready_o| morph_speed
//
// each vertex is worked through three morph divisions by 1000, each a multiply, the
// start and the 46 step shared bit-serial divider. the third vertex then adds the shrink
// shifts, six cross product multiplies, a 32 step square root and three more divisions
// (a zero normal goes straight to output), then three result items. one item is worked
// at a time; input is taken only when idle. reset clears the vertex count and sets the
// speed to one.
`timescale 1ns / 1ps
module morph_face_and_normal_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [mfn_pkg::CW-1:0] cur_x_i,
  input  logic signed [mfn_pkg::CW-1:0] cur_y_i,
  input  logic signed [mfn_pkg::CW-1:0] cur_z_i,
  input  logic signed [mfn_pkg::CW-1:0] delta_x_i,
  input  logic signed [mfn_pkg::CW-1:0] delta_y_i,
  input  logic signed [mfn_pkg::CW-1:0] delta_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    vertex_slot_o,
  output logic signed [mfn_pkg::CW-1:0] new_x_o,
  output logic signed [mfn_pkg::CW-1:0] new_y_o,
  output logic signed [mfn_pkg::CW-1:0] new_z_o,
  output logic signed [mfn_pkg::NW-1:0] normal_x_o,
  output logic signed [mfn_pkg::NW-1:0] normal_y_o,
  output logic signed [mfn_pkg::NW-1:0] normal_z_o,
  output logic                          last_of_face_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic signed [mfn_pkg::SW-1:0] cfg_morph_speed_i
);
  import mfn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MDIV, S_MWAIT, S_POST, S_SHR, S_XMUL, S_XACC,
    S_NCHK, S_NSH, S_SQ, S_SQA, S_SQRT, S_NDIV, S_NWAIT, S_OUT
  } state_e;

  localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

  state_e       state_q;
  logic [1:0]   k_q;
  logic [2:0]   j_q;
  logic [1:0]   slot_q;
  logic [1:0]   oidx_q;
  logic [SW-1:0] speed_q;

  logic [CW-1:0]   cur_q [3];
  logic [CW-1:0]   dlt_q [3];
  logic [CW-1:0]   nv_q  [3];
  logic [CW-1:0]   a_q   [3];
  logic [CW-1:0]   b_q   [3];
  logic signed [PW-1:0] prod_q;
  logic            v1s_q [3];
  logic            v2s_q [3];
  logic [VMW-1:0]  v1m_q [3];
  logic [VMW-1:0]  v2m_q [3];
  logic [2*MW-1:0] mprod_q;
  logic            psgn_q;
  logic signed [NACC-1:0] nacc_q [3];
  logic            ns_q  [3];
  logic [NMW-1:0]  nm_q  [3];
  logic [SQW-1:0]  sum_q;
  logic [SQW-1:0]  x_q;
  logic [RW-1:0]   r_q;
  logic [RW-1:0]   bit_q;
  logic [NW-1:0]   nrm_q [3];

  logic            div_start;
  logic            div_done;
  logic [DVW-1:0]  div_dividend;
  logic [DSW-1:0]  div_divisor;
  logic [DVW-1:0]  div_quo;

  logic [PW-1:0]   pmag;
  logic signed [SUMW-1:0] msum;
  logic [CW-1:0]   msat;
  logic            v1_hi, v2_hi, n_hi, n_lo, n_zero;
  logic [1:0]      xa, xb;
  logic [RW-1:0]   sq_t;
  logic [MW:0]     len;
  logic [NUMW-1:0] ndvd;
  logic [NW-1:0]   qn;

  // ---------------- combinational helpers ----------------
  always_comb begin
    pmag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    msum = SUMW'($signed(cur_q[k_q]))
         + (prod_q[PW-1] ? -$signed(SUMW'(div_quo)) : $signed(SUMW'(div_quo)));
    if (msum > SAT_HI)      msat = SAT_HI[CW-1:0];
    else if (msum < SAT_LO) msat = SAT_LO[CW-1:0];
    else                    msat = msum[CW-1:0];

    v1_hi  = 1'b0;
    v2_hi  = 1'b0;
    n_hi   = 1'b0;
    n_lo   = 1'b1;
    n_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      v1_hi  = v1_hi  | (({1'b0, v1m_q[i]} >> MW) != '0);
      v2_hi  = v2_hi  | (({1'b0, v2m_q[i]} >> MW) != '0);
      n_hi   = n_hi   | ((nm_q[i] >> MW) != '0);
      n_lo   = n_lo   & ((nm_q[i] >> (MW - 1)) == '0);
      n_zero = n_zero & (nacc_q[i] == '0);
    end

    xa   = xa_idx(j_q);
    xb   = xb_idx(j_q);
    sq_t = r_q + bit_q;
    len  = r_q[MW:0];
    ndvd = NUMW'({nm_q[k_q][MW-1:0], {(NW-1){1'b0}}}) + NUMW'(len);
    qn   = div_quo[NW-1:0];

    div_start = (state_q == S_MDIV) || (state_q == S_NDIV);
    if (state_q == S_MDIV) begin
      div_dividend = DVW'(pmag);
      div_divisor  = DSW'(MORPH_DIV);
    end else begin
      div_dividend = DVW'(ndvd);
      div_divisor  = {len, 1'b0};
    end
  end

  mfn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      j_q     <= '0;
      slot_q  <= '0;
      oidx_q  <= '0;
      speed_q <= SW'(1);
    end else begin
      if (cfg_valid_i) begin
        speed_q <= cfg_morph_speed_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            k_q     <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL:  state_q <= S_MDIV;
        S_MDIV: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (div_done) begin
            if (k_q == 2'd2) begin
              state_q <= S_POST;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_MUL;
            end
          end
        end
        S_POST: begin
          if (slot_q < 2'd2) begin
            slot_q  <= slot_q + 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SHR;
          end
        end
        S_SHR: begin
          if (!v1_hi && !v2_hi) begin
            j_q     <= '0;
            state_q <= S_XMUL;
          end
        end
        S_XMUL: state_q <= S_XACC;
        S_XACC: begin
          j_q <= j_q + 1'b1;
          state_q <= (j_q == 3'd5) ? S_NCHK : S_XMUL;
        end
        S_NCHK: begin
          oidx_q  <= '0;
          state_q <= n_zero ? S_OUT : S_NSH;
        end
        S_NSH: begin
          if (!n_hi && !n_lo) begin
            k_q     <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: state_q <= S_SQA;
        S_SQA: begin
          if (k_q == 2'd2) begin
            state_q <= S_SQRT;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_SQ;
          end
        end
        S_SQRT: begin
          if (bit_q[0]) begin
            k_q     <= '0;
            state_q <= S_NDIV;
          end
        end
        S_NDIV: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (div_done) begin
            if (k_q == 2'd2) begin
              oidx_q  <= '0;
              state_q <= S_OUT;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_NDIV;
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 1'b1;
            if (oidx_q == 2'd2) begin
              slot_q  <= '0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cur_q[0] <= cur_x_i;
        cur_q[1] <= cur_y_i;
        cur_q[2] <= cur_z_i;
        dlt_q[0] <= delta_x_i;
        dlt_q[1] <= delta_y_i;
        dlt_q[2] <= delta_z_i;
      end
      S_MUL: begin
        prod_q <= $signed(speed_q) * $signed(dlt_q[k_q]);
      end
      S_MWAIT: begin
        if (div_done) begin
          nv_q[k_q] <= msat;
        end
      end
      S_POST: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [VW-1:0] d1, d2;
          d1 = $signed({a_q[i][CW-1], a_q[i]}) - $signed({b_q[i][CW-1], b_q[i]});
          d2 = $signed({nv_q[i][CW-1], nv_q[i]}) - $signed({a_q[i][CW-1], a_q[i]});
          v1s_q[i] <= d1[VW-1];
          v2s_q[i] <= d2[VW-1];
          v1m_q[i] <= VMW'(d1[VW-1] ? VW'(-d1) : VW'(d1));
          v2m_q[i] <= VMW'(d2[VW-1] ? VW'(-d2) : VW'(d2));
          nacc_q[i] <= '0;
        end
        if (slot_q == 2'd0) begin
          for (int i = 0; i < 3; i++) a_q[i] <= nv_q[i];
        end else if (slot_q == 2'd1) begin
          for (int i = 0; i < 3; i++) b_q[i] <= nv_q[i];
        end
      end
      S_SHR: begin
        for (int i = 0; i < 3; i++) begin
          if (v1_hi) v1m_q[i] <= v1m_q[i] >> 1;
          if (v2_hi) v2m_q[i] <= v2m_q[i] >> 1;
        end
      end
      S_XMUL: begin
        mprod_q <= v1m_q[xa][MW-1:0] * v2m_q[xb][MW-1:0];
        psgn_q  <= v1s_q[xa] ^ v2s_q[xb] ^ j_q[0];
      end
      S_XACC: begin
        nacc_q[j_q[2:1]] <= nacc_q[j_q[2:1]]
          + (psgn_q ? -$signed(NACC'(mprod_q)) : $signed(NACC'(mprod_q)));
      end
      S_NCHK: begin
        for (int i = 0; i < 3; i++) begin
          ns_q[i]  <= nacc_q[i][NACC-1];
          nm_q[i]  <= nacc_q[i][NACC-1] ? NMW'(-nacc_q[i]) : NMW'(nacc_q[i]);
          nrm_q[i] <= '0;
        end
        sum_q <= '0;
      end
      S_NSH: begin
        for (int i = 0; i < 3; i++) begin
          if (n_hi)      nm_q[i] <= nm_q[i] >> 1;
          else if (n_lo) nm_q[i] <= nm_q[i] << 1;
        end
      end
      S_SQ: begin
        mprod_q <= nm_q[k_q][MW-1:0] * nm_q[k_q][MW-1:0];
      end
      S_SQA: begin
        sum_q <= sum_q + SQW'(mprod_q);
        x_q   <= sum_q + SQW'(mprod_q);
        r_q   <= '0;
        bit_q <= RW'(1) << SQW;
      end
      S_SQRT: begin
        // classic bit-pair square root, one result bit per cycle
        if ({1'b0, x_q} >= sq_t) begin
          x_q <= x_q - sq_t[SQW-1:0];
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_NWAIT: begin
        if (div_done) begin
          nrm_q[k_q] <= ns_q[k_q] ? NW'(-qn) : qn;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- ports ----------------
  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = (state_q == S_OUT);
  assign vertex_slot_o  = oidx_q;
  assign last_of_face_o = (oidx_q == 2'd2);
  assign normal_x_o     = nrm_q[0];
  assign normal_y_o     = nrm_q[1];
  assign normal_z_o     = nrm_q[2];

  always_comb begin
    unique case (oidx_q)
      2'd0: begin
        new_x_o = a_q[0];
        new_y_o = a_q[1];
        new_z_o = a_q[2];
      end
      2'd1: begin
        new_x_o = b_q[0];
        new_y_o = b_q[1];
        new_z_o = b_q[2];
      end
      default: begin
        new_x_o = nv_q[0];
        new_y_o = nv_q[1];
        new_z_o = nv_q[2];
      end
    endcase
  end

endmodule

>>> rtl/mfn_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mfn_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [mfn_pkg::DVW-1:0] dividend_i,
  input  logic [mfn_pkg::DSW-1:0] divisor_i,
  output logic                   done_o,
  output logic [mfn_pkg::DVW-1:0] quotient_o
);
  import mfn_pkg::*;

  localparam int CNTW = $clog2(DVW);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DSW-1:0]  rem_q;
  logic [DSW-1:0]  dsr_q;
  logic [DVW-1:0]  quo_q;

  logic [DSW:0] rem_sh;
  logic [DSW:0] rem_nx;
  logic         ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DVW-1]};
    ge     = (rem_sh >= {1'b0, dsr_q});
    rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(DVW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVW-2:0], ge};
      rem_q <= rem_nx[DSW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> dv/mfn_checker.sv
// checker for the face morph and normal block: predicts results and compares them
`timescale 1ns / 1ps
module mfn_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [mfn_pkg::CW-1:0] cur_x_i,
  input  logic signed [mfn_pkg::CW-1:0] cur_y_i,
  input  logic signed [mfn_pkg::CW-1:0] cur_z_i,
  input  logic signed [mfn_pkg::CW-1:0] delta_x_i,
  input  logic signed [mfn_pkg::CW-1:0] delta_y_i,
  input  logic signed [mfn_pkg::CW-1:0] delta_z_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    vertex_slot_i,
  input  logic signed [mfn_pkg::CW-1:0] new_x_i,
  input  logic signed [mfn_pkg::CW-1:0] new_y_i,
  input  logic signed [mfn_pkg::CW-1:0] new_z_i,
  input  logic signed [mfn_pkg::NW-1:0] normal_x_i,
  input  logic signed [mfn_pkg::NW-1:0] normal_y_i,
  input  logic signed [mfn_pkg::NW-1:0] normal_z_i,
  input  logic                          last_of_face_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic signed [mfn_pkg::SW-1:0] cfg_morph_speed_i,
  output int                            errors_o,
  output int                            pending_o
);
  import mfn_pkg::*;

  typedef struct {
    logic [1:0]           slot;
    logic signed [CW-1:0] x, y, z;
    logic signed [NW-1:0] nx, ny, nz;
    logic                 last;
  } vertex_res_t;

  localparam longint unsigned MAG_HI = 64'd1 << 30;
  localparam longint unsigned MAG_LO = 64'd1 << 29;

  vertex_res_t          face_q[$];
  logic signed [SW-1:0] speed;
  longint               held_a[3], held_b[3];
  int                   n_held;
  int                   errors;
  int                   pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint with_sign(longint like, longint unsigned m);
    return (like < 0) ? -longint'(m) : longint'(m);
  endfunction

  // shift count that brings the largest magnitude below 2^30
  function automatic int shrink_amt(longint a, longint b, longint c);
    longint unsigned mx;
    int              s;
    mx = mag(a);
    if (mag(b) > mx) mx = mag(b);
    if (mag(c) > mx) mx = mag(c);
    s = 0;
    while ((mx >> s) >= MAG_HI) s++;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint morph_coord(logic signed [CW-1:0] cur, logic signed [CW-1:0] d,
                                         logic signed [SW-1:0] spd);
    longint v;
    v = longint'(cur) + (longint'(spd) * longint'(d)) / MORPH_DIV;
    if (v > 64'sh7fff_ffff) v = 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v;
  endfunction

  // unit normal of (a - b) x (c - a), Q2.14
  function automatic void face_normal(longint a[3], longint b[3], longint c[3],
                                      output logic signed [NW-1:0] nrm[3]);
    longint          v1[3], v2[3], n[3];
    longint unsigned mx, sum, len;
    int              s;
    for (int k = 0; k < 3; k++) begin
      v1[k] = a[k] - b[k];
      v2[k] = c[k] - a[k];
    end
    s = shrink_amt(v1[0], v1[1], v1[2]);
    for (int k = 0; k < 3; k++) v1[k] = with_sign(v1[k], mag(v1[k]) >> s);
    s = shrink_amt(v2[0], v2[1], v2[2]);
    for (int k = 0; k < 3; k++) v2[k] = with_sign(v2[k], mag(v2[k]) >> s);
    n[0] = v1[1] * v2[2] - v1[2] * v2[1];
    n[1] = v1[2] * v2[0] - v1[0] * v2[2];
    n[2] = v1[0] * v2[1] - v1[1] * v2[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      for (int k = 0; k < 3; k++) nrm[k] = '0;
      return;
    end
    s = shrink_amt(n[0], n[1], n[2]);
    for (int k = 0; k < 3; k++) n[k] = with_sign(n[k], mag(n[k]) >> s);
    mx = mag(n[0]);
    if (mag(n[1]) > mx) mx = mag(n[1]);
    if (mag(n[2]) > mx) mx = mag(n[2]);
    while (mx < MAG_LO) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) n[k] = with_sign(n[k], mag(n[k]) << 1);
    end
    sum = 0;
    for (int k = 0; k < 3; k++) sum += mag(n[k]) * mag(n[k]);
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++)
      nrm[k] = NW'(with_sign(n[k], (2 * mag(n[k]) * (64'd1 << (NW - 2)) + len) / (2 * len)));
  endfunction

  task automatic take_vertex();
    longint               nv[3], face[3][3];
    logic signed [NW-1:0] nrm[3];
    vertex_res_t          r;
    nv[0] = morph_coord(cur_x_i, delta_x_i, speed);
    nv[1] = morph_coord(cur_y_i, delta_y_i, speed);
    nv[2] = morph_coord(cur_z_i, delta_z_i, speed);
    if (n_held == 0) begin
      held_a = nv;
      n_held = 1;
    end else if (n_held == 1) begin
      held_b = nv;
      n_held = 2;
    end else begin
      face_normal(held_a, held_b, nv, nrm);
      face[0] = held_a;
      face[1] = held_b;
      face[2] = nv;
      for (int v = 0; v < 3; v++) begin
        r.slot = 2'(v);
        r.x    = CW'(face[v][0]);
        r.y    = CW'(face[v][1]);
        r.z    = CW'(face[v][2]);
        r.nx   = nrm[0];
        r.ny   = nrm[1];
        r.nz   = nrm[2];
        r.last = (v == 2);
        face_q.insert(face_q.size(), r);
      end
      n_held = 0;
    end
  endtask

  task automatic check_vertex();
    vertex_res_t e;
    if (face_q.size() == 0) begin
      $display("%0t: unexpected result item slot %0d", $realtime, vertex_slot_i);
      errors++;
      return;
    end
    e = face_q.pop_front();
    if (vertex_slot_i !== e.slot || new_x_i !== e.x || new_y_i !== e.y || new_z_i !== e.z ||
        normal_x_i !== e.nx || normal_y_i !== e.ny || normal_z_i !== e.nz ||
        last_of_face_i !== e.last) begin
      $display("%0t: expected slot %0d xyz %0d %0d %0d n %0d %0d %0d last %0b", $realtime,
               e.slot, e.x, e.y, e.z, e.nx, e.ny, e.nz, e.last);
      $display("%0t: actual   slot %0d xyz %0d %0d %0d n %0d %0d %0d last %0b", $realtime,
               vertex_slot_i, new_x_i, new_y_i, new_z_i, normal_x_i, normal_y_i,
               normal_z_i, last_of_face_i);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed  = SW'(1);
      n_held = 0;
      errors = 0;
      face_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_vertex();
      if (in_valid_i && in_ready_i) take_vertex();
      if (cfg_valid_i && cfg_ready_i) speed = cfg_morph_speed_i;
    end
    pending = face_q.size();
  end

endmodule

>>> dv/tb_morph_face_and_normal_top.sv
// testbench top for the face morph and normal block: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_morph_face_and_normal_top;
  import mfn_pkg::*;

  localparam int SETTLE = 800;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [CW-1:0] cur_x_i = '0, cur_y_i = '0, cur_z_i = '0;
  logic signed [CW-1:0] delta_x_i = '0, delta_y_i = '0, delta_z_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           vertex_slot_o;
  logic signed [CW-1:0] new_x_o, new_y_o, new_z_o;
  logic signed [NW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic                 last_of_face_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic signed [SW-1:0] cfg_morph_speed_i = '0;
  int                   errors, pending;
  int                   tx_idle = 34, rx_idle = 68;
  int                   hold_cycles = 0;

  morph_face_and_normal_top i_dut (.*);

  mfn_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .cur_x_i, .cur_y_i, .cur_z_i, .delta_x_i, .delta_y_i, .delta_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .vertex_slot_i(vertex_slot_o), .new_x_i(new_x_o), .new_y_i(new_y_o), .new_z_i(new_z_o),
    .normal_x_i(normal_x_o), .normal_y_i(normal_y_o), .normal_z_i(normal_z_o),
    .last_of_face_i(last_of_face_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_morph_speed_i,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_vertex(logic [CW-1:0] cx, cy, cz, dx, dy, dz);
    logic rdy;
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    cur_x_i   <= cx;
    cur_y_i   <= cy;
    cur_z_i   <= cz;
    delta_x_i <= dx;
    delta_y_i <= dy;
    delta_z_i <= dz;
    in_valid_i <= 1'b1;
    forever begin
      #1 rdy = in_ready_o;
      @(posedge clk_i);
      if (rdy) break;
      @(negedge clk_i);
    end
  endtask

  // only between faces, once all results are back and the datapath has drained
  task automatic write_speed(logic signed [SW-1:0] spd);
    logic rdy;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk_i);
    cfg_morph_speed_i <= spd;
    cfg_valid_i       <= 1'b1;
    forever begin
      #1 rdy = cfg_ready_o;
      @(posedge clk_i);
      if (rdy) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_face(logic [CW-1:0] c[9], logic [CW-1:0] d[9]);
    for (int v = 0; v < 3; v++)
      send_vertex(c[3*v], c[3*v+1], c[3*v+2], d[3*v], d[3*v+1], d[3*v+2]);
  endtask

  task automatic random_faces(int n_faces);
    logic [CW-1:0] c[9], d[9];
    int            kind;
    for (int f = 0; f < n_faces; f++) begin
      kind = $urandom_range(9);
      for (int k = 0; k < 9; k++) begin
        if (kind == 0) begin
          // degenerate: every vertex at one point, zero normal
          c[k] = (k < 3) ? $urandom : c[k - 3];
          d[k] = (k < 3) ? $urandom : d[k - 3];
        end else if (kind < 6) begin
          c[k] = CW'($signed($urandom_range(2 ** 21)) - 2 ** 20);
          d[k] = CW'($signed($urandom_range(2 ** 23)) - 2 ** 22);
        end else begin
          c[k] = $urandom;
          d[k] = $urandom;
        end
      end
      send_face(c, d);
    end
  endtask

  initial begin
    logic [CW-1:0] c[9], d[9];
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // unit speed: axis triangle, degenerate point, full range corners
    c = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
    d = '{default: 0};
    send_face(c, d);
    c = '{default: 32'h0012_3456};
    d = '{default: 32'hfff0_0000};
    send_face(c, d);
    c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0};
    d = '{32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 0,
          32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    send_face(c, d);

    write_speed(12'sd1024);
    c = '{32'h7ff0_0000, 0, 32'h8010_0000, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 0};
    d = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h0000_0001, 32'h8000_0000, 32'h0000_03e7, 32'hffff_fc19};
    send_face(c, d);
    write_speed(-12'sd1024);
    send_face(c, d);
    random_faces(12);

    tx_idle = 68;
    rx_idle = 34;
    write_speed(SW'(-2048));
    random_faces(6);
    write_speed(12'sd2047);
    random_faces(6);

    tx_idle = 0;
    rx_idle = 0;
    write_speed(SW'($urandom_range(2048) - 1024));
    @(negedge clk_i);
    hold_cycles = 3000;
    random_faces(10);
    write_speed(12'sd0);
    random_faces(3);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> morph_face_and_normal_top.f
rtl/mfn_pkg.sv
rtl/mfn_div.sv
rtl/morph_face_and_normal_top.sv
dv/mfn_checker.sv
dv/tb_morph_face_and_normal_top.sv
